FILE: sv/assert_macros.svh
// Shared assertion macros for the frame formatter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/etxf_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet TX frame formatter package
// Shared constants, the per-item run plan type and the header byte select.
// ----------------------------------------------------------------------------
package etxf_pkg;

  localparam int unsigned MinPayload = 46;
  localparam int unsigned HdrLen     = 14;
  // Wide enough for the longest run of one item, header plus full padding.
  localparam int unsigned CntW       = $clog2(HdrLen + MinPayload + 1);

  // Plan for the run of output bytes caused by one accepted item.
  typedef struct packed {
    logic            hdr;        // emit the 14-byte header first
    logic            pay;        // emit the payload byte
    logic [CntW-1:0] len_m1;     // run length minus one
    logic            frame_end;  // run closes the frame
  } plan_t;

  // Header byte at position idx: destination, source, then type, MSB first.
  function automatic logic [7:0] hdr_byte(input logic [47:0] dest,
                                          input logic [47:0] src,
                                          input logic [15:0] etype,
                                          input logic [3:0]  idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = dest[47:40];
      4'd1:    b = dest[39:32];
      4'd2:    b = dest[31:24];
      4'd3:    b = dest[23:16];
      4'd4:    b = dest[15:8];
      4'd5:    b = dest[7:0];
      4'd6:    b = src[47:40];
      4'd7:    b = src[39:32];
      4'd8:    b = src[31:24];
      4'd9:    b = src[23:16];
      4'd10:   b = src[15:8];
      4'd11:   b = src[7:0];
      4'd12:   b = etype[15:8];
      4'd13:   b = etype[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/etxf_plan.sv
// ----------------------------------------------------------------------------
// Frame tracker and run planner
// Keeps the per-frame state and works out the output run of each item.
// ----------------------------------------------------------------------------
module etxf_plan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                first_byte,
  input  logic                last_byte,
  input  logic                empty_frame,
  input  logic [47:0]         dest_mac,
  input  logic [47:0]         local_mac,
  output logic                plan_valid,
  output etxf_pkg::plan_t     plan
);
  import etxf_pkg::*;

  localparam logic [CntW-1:0] MinCnt = CntW'(MinPayload);
  localparam logic [CntW-1:0] HdrCnt = CntW'(HdrLen);

  logic            in_frame_r, in_frame_nxt;
  logic            drop_r, drop_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  logic            first, last, ignore, drop, pay;
  logic [CntW-1:0] cnt0, cnt1, pad, len;

  // Work out the run for the item on the input.
  always_comb begin
    first  = first_byte | empty_frame;
    last   = last_byte | empty_frame;
    ignore = !first && !in_frame_r;
    cnt0   = first ? '0 : cnt_r;
    drop   = first ? (dest_mac == local_mac) : drop_r;
    pay    = !empty_frame;
    cnt1   = (pay && (cnt0 < MinCnt)) ? cnt0 + CntW'(1) : cnt0;
    pad    = last ? MinCnt - cnt1 : '0;
    len    = (first ? HdrCnt : '0) + CntW'(pay) + pad;

    plan_valid     = !ignore && !drop;
    plan.hdr       = first;
    plan.pay       = pay;
    plan.len_m1    = len - CntW'(1);
    plan.frame_end = last;
  end

  // Frame state after the item.
  always_comb begin
    in_frame_nxt = in_frame_r;
    drop_nxt     = drop_r;
    cnt_nxt      = cnt_r;
    if (in_fire && !ignore) begin
      if (last) begin
        in_frame_nxt = 1'b0;
        drop_nxt     = 1'b0;
        cnt_nxt      = '0;
      end else begin
        in_frame_nxt = 1'b1;
        drop_nxt     = drop;
        cnt_nxt      = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      drop_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      drop_r     <= drop_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

FILE: sv/etxf_emit.sv
// ----------------------------------------------------------------------------
// Run emitter
// Holds one planned item and sends its bytes through the output register.
// ----------------------------------------------------------------------------
module etxf_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                plan_valid,
  input  etxf_pkg::plan_t     plan,
  input  logic [7:0]          payload_byte,
  input  logic [47:0]         dest_mac,
  input  logic [15:0]         ethertype,
  input  logic [47:0]         local_mac,
  output logic                hold_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                frame_last
);
  import etxf_pkg::*;

  localparam logic [CntW-1:0] HdrCnt = CntW'(HdrLen);

  logic            hold_v_r, hold_v_nxt;
  plan_t           plan_r;
  logic [7:0]      pbyte_r;
  logic [47:0]     dest_r;
  logic [15:0]     etype_r;
  logic [CntW-1:0] idx_r, idx_nxt;

  logic            out_v_r, out_v_nxt;
  logic [7:0]      out_byte_r;
  logic            run_last_r, frame_last_r;

  logic            step, at_end;
  logic [7:0]      byte_sel;
  logic [CntW-1:0] pay_pos;

  // One byte leaves the hold stage whenever the output register can take it.
  assign step      = hold_v_r && (!out_v_r || out_ready);
  assign at_end    = (idx_r == plan_r.len_m1);
  assign hold_free = !hold_v_r || (step && at_end);

  // Byte at the current run position.
  always_comb begin
    pay_pos = plan_r.hdr ? HdrCnt : '0;
    if (plan_r.hdr && (idx_r < HdrCnt)) begin
      byte_sel = hdr_byte(dest_r, local_mac, etype_r, idx_r[3:0]);
    end else if (plan_r.pay && (idx_r == pay_pos)) begin
      byte_sel = pbyte_r;
    end else begin
      byte_sel = 8'h00;
    end
  end

  // Hold stage control.
  always_comb begin
    hold_v_nxt = hold_v_r;
    idx_nxt    = idx_r;
    if (step) begin
      idx_nxt = idx_r + CntW'(1);
      if (at_end) begin
        hold_v_nxt = 1'b0;
      end
    end
    if (in_fire && plan_valid) begin
      hold_v_nxt = 1'b1;
      idx_nxt    = '0;
    end
  end

  // Output register control.
  always_comb begin
    out_v_nxt = out_v_r;
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_fire && plan_valid) begin
      plan_r  <= plan;
      pbyte_r <= payload_byte;
      dest_r  <= dest_mac;
      etype_r <= ethertype;
    end
    if (step) begin
      out_byte_r   <= byte_sel;
      run_last_r   <= at_end;
      frame_last_r <= at_end && plan_r.frame_end;
    end
  end

  assign out_valid  = out_v_r;
  assign out_byte   = out_byte_r;
  assign run_last   = run_last_r;
  assign frame_last = frame_last_r;

endmodule

FILE: sv/ethernet_tx_frame_formatter_unit.sv
// Path: an item's run goes through the hold stage, then the output register, to out_tdata.
// Throughput: one output byte per cycle while out_tready is high; a payload item is 1 byte, an
// opening 15 or more, a closing 1 + padding; the single hold stage and byte counter set this.
// Reset: synchronous, active low; clears frame state, local MAC and both valid flags.
// ----------------------------------------------------------------------------
// Ethernet TX frame formatter
// Inserts the Ethernet header, passes payload, pads to the minimum payload; drops own-MAC frames.
// ----------------------------------------------------------------------------
module ethernet_tx_frame_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,     // local_mac
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,      // payload_byte[7:0], dest_mac[55:8], ethertype[71:56]
  input  logic [1:0]  in_tuser,      // first_byte[0], empty_frame[1]
  input  logic        in_tlast,      // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // out_byte[7:0]
  output logic [0:0]  out_tuser,     // run_last[0]
  output logic        out_tlast      // frame_last
);
  import etxf_pkg::*;

  logic [47:0] local_mac_r;
  logic        in_fire;
  logic        plan_valid;
  plan_t       plan;
  logic        hold_free;
  logic        run_last;

  // Station address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= '0;
    end else if (cfg_we) begin
      local_mac_r <= cfg_wdata;
    end
  end

  assign in_tready = hold_free;
  assign in_fire   = in_tvalid && in_tready;

  etxf_plan u_plan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .first_byte  (in_tuser[0]),
    .last_byte   (in_tlast),
    .empty_frame (in_tuser[1]),
    .dest_mac    (in_tdata[55:8]),
    .local_mac   (local_mac_r),
    .plan_valid  (plan_valid),
    .plan        (plan)
  );

  etxf_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .plan_valid   (plan_valid),
    .plan         (plan),
    .payload_byte (in_tdata[7:0]),
    .dest_mac     (in_tdata[55:8]),
    .ethertype    (in_tdata[71:56]),
    .local_mac    (local_mac_r),
    .hold_free    (hold_free),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .run_last     (run_last),
    .frame_last   (out_tlast)
  );

  assign out_tuser[0] = run_last;

endmodule

FILE: sv/etxf_checker.sv
// ----------------------------------------------------------------------------
// Frame formatter port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etxf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  // A stalled output beat keeps its byte.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The end of a frame always closes the run of its item.
  `ASSERT_IMP(a_frame_run, clk, rst_n, out_tvalid && out_tlast, out_tuser[0])

  // Reset empties the output register.
  `ASSERT_NXT(a_rst_out, clk, 1'b1, !rst_n, !out_tvalid)

  // Reset leaves the block ready for a new beat.
  `ASSERT_NXT(a_rst_rdy, clk, 1'b1, !rst_n, in_tready)

endmodule

bind ethernet_tx_frame_formatter_unit etxf_checker u_etxf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet TX frame formatter testbench
// Streams payload beats through the formatter under random source gaps and sink
// stalls. A local predictor builds the expected header, payload and padding
// bytes for every accepted beat, and each output beat is checked against them.
// ----------------------------------------------------------------------------
module tb_top;
  import etxf_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned MaxReports   = 10;

  // Entries of the stimulus queue: a data beat, a station address write, or a
  // pause until the formatter has emptied out.
  typedef enum logic [1:0] {STIM_BEAT, STIM_CFG, STIM_QUIESCE} stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    logic [7:0]  pay;
    logic        first;
    logic        last;
    logic        empty;
    logic [47:0] dest;
    logic [15:0] etype;
    logic [47:0] mac;
  } stim_t;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       frame_end;
  } tx_byte_t;

  // Sink behavior modes.
  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_BURSTY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;     // payload_byte[7:0], dest_mac[55:8], ethertype[71:56]
  logic [1:0]  in_tuser = '0;     // first_byte[0], empty_frame[1]
  logic        in_tlast = 1'b0;   // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // out_byte[7:0]
  logic [0:0]  out_tuser;         // run_last[0]
  logic        out_tlast;         // frame_last

  stim_t       pending_q[$];
  tx_byte_t    frame_bytes_q[$];
  int unsigned stim_items = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        in_beat_taken = 1'b0;

  // Predictor state.
  logic [47:0] station_mac = '0;
  int unsigned pay_sent = 0;
  logic        frame_dropping = 1'b0;
  logic        frame_open = 1'b0;

  // Source pacing state.
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  int unsigned settle_left = 0;
  logic        quiescing = 1'b0;

  // Sink pacing state.
  rx_mode_t    rx_mode = RX_STEADY;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;

  ethernet_tx_frame_formatter_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic push_beat(input logic [7:0] pay, input logic first, input logic last,
                           input logic empty, input logic [47:0] dest,
                           input logic [15:0] etype);
    stim_t s;
    s.kind  = STIM_BEAT;
    s.pay   = pay;
    s.first = first;
    s.last  = last;
    s.empty = empty;
    s.dest  = dest;
    s.etype = etype;
    s.mac   = '0;
    pending_q.push_back(s);
    stim_items++;
  endtask

  task automatic push_station_mac(input logic [47:0] mac);
    stim_t s;
    s = '{kind: STIM_CFG, pay: '0, first: 1'b0, last: 1'b0, empty: 1'b0,
          dest: '0, etype: '0, mac: mac};
    pending_q.push_back(s);
  endtask

  task automatic push_quiesce();
    stim_t s;
    s = '{kind: STIM_QUIESCE, pay: '0, first: 1'b0, last: 1'b0, empty: 1'b0,
          dest: '0, etype: '0, mac: '0};
    pending_q.push_back(s);
  endtask

  // A frame of len beats; when closed is clear the frame is left open so the
  // next opening beat abandons it.
  task automatic push_frame(input int unsigned len, input logic [47:0] dest,
                            input logic closed);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      push_beat(8'($urandom_range(0, 255)), k == 0, closed && (k == len - 1), 1'b0,
                (k == 0) ? dest : rand48(), 16'($urandom_range(0, 65535)));
    end
  endtask

  // Expected bytes for one accepted beat: header on an opening beat, the
  // payload byte, and zero padding on a closing beat.
  task automatic format_frame_bytes(input logic [7:0] pay, input logic first,
                                    input logic last, input logic empty,
                                    input logic [47:0] dest, input logic [15:0] etype);
    logic [7:0] run[$];
    tx_byte_t   b;
    int         k;
    logic       opening;
    logic       closing;
    logic       frame_done;
    opening    = first || empty;
    closing    = last || empty;
    frame_done = 1'b0;
    if (opening) begin
      frame_open     = 1'b1;
      pay_sent       = 0;
      frame_dropping = (dest == station_mac);
      if (!frame_dropping) begin
        for (k = 5; k >= 0; k--) run.push_back(dest[8*k +: 8]);
        for (k = 5; k >= 0; k--) run.push_back(station_mac[8*k +: 8]);
        run.push_back(etype[15:8]);
        run.push_back(etype[7:0]);
      end
    end else if (!frame_open) begin
      return;
    end
    if (!empty) begin
      if (!frame_dropping) run.push_back(pay);
      if (pay_sent < MinPayload) pay_sent++;
    end
    if (closing) begin
      if (!frame_dropping) begin
        while (pay_sent < MinPayload) begin
          run.push_back(8'h00);
          pay_sent++;
        end
        frame_done = 1'b1;
      end
      frame_open     = 1'b0;
      frame_dropping = 1'b0;
      pay_sent       = 0;
    end
    for (k = 0; k < run.size(); k++) begin
      b.data      = run[k];
      b.run_end   = (k == run.size() - 1);
      b.frame_end = frame_done && (k == run.size() - 1);
      frame_bytes_q.push_back(b);
    end
  endtask

  // Source driver: pops the stimulus queue at the falling edge, holding a beat
  // until it is taken.
  always @(negedge clk) begin
    stim_t s;
    logic  vld;
    logic  we;
    vld = in_tvalid && !in_beat_taken;
    we  = 1'b0;
    if (rst_n && !vld) begin
      if (settle_left > 0) begin
        settle_left--;
      end else if (quiescing) begin
        if (frame_bytes_q.size() == 0) begin
          quiescing   = 1'b0;
          settle_left = SettleCycles;
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        s = pending_q.pop_front();
        case (s.kind)
          STIM_QUIESCE: begin
            quiescing = 1'b1;
          end
          STIM_CFG: begin
            we = 1'b1;
            cfg_wdata <= s.mac;
          end
          default: begin
            vld = 1'b1;
            in_tdata <= {s.etype, s.dest, s.pay};
            in_tuser <= {s.empty, s.first};
            in_tlast <= s.last;
            burst_left--;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        endcase
      end
    end
    in_tvalid <= vld;
    cfg_we    <= we;
  end

  // Sink driver: switches between steady, choppy and long-stall behavior.
  always @(negedge clk) begin
    logic rdy;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'(2'($urandom_range(0, 2)));
      rx_mode_left = $urandom_range(40, 200);
    end else begin
      rx_mode_left--;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: rdy = 1'b1;
        RX_CHOPPY: rdy = 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_stall_left = $urandom_range(3, 20);
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
      endcase
    end
    out_tready <= rdy;
  end

  // Monitor: tracks register writes and input beats for the predictor, then
  // checks every output beat against the oldest expected byte.
  always @(posedge clk) begin
    tx_byte_t e;
    in_beat_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && cfg_we) station_mac = cfg_wdata;
    if (rst_n && in_tvalid && in_tready) begin
      format_frame_bytes(in_tdata[7:0], in_tuser[0], in_tlast, in_tuser[1],
                         in_tdata[55:8], in_tdata[71:56]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_bytes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected beat: byte %02h run_last %0b frame_last %0b",
                   out_tdata, out_tuser[0], out_tlast);
      end else begin
        e = frame_bytes_q.pop_front();
        if (out_tdata !== e.data || out_tuser[0] !== e.run_end ||
            out_tlast !== e.frame_end) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: expected byte %02h run_last %0b frame_last %0b, got %02h %0b %0b",
                     e.data, e.run_end, e.frame_end, out_tdata, out_tuser[0], out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles with no activity on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    logic [47:0] phase_macs[4];
    logic [47:0] dest;
    logic [47:0] mac;
    int unsigned p;
    int unsigned start;
    int unsigned len;
    int unsigned pick;

    // Directed part with the station address at all ones.
    push_station_mac(48'hFFFF_FFFF_FFFF);
    push_beat(8'hFF, 1'b0, 1'b0, 1'b1, 48'h0000_0000_0000, 16'hFFFF);
    push_beat(8'h00, 1'b1, 1'b0, 1'b0, 48'h0123_4567_89AB, 16'h0800);
    push_beat(8'hFF, 1'b0, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    push_beat(8'h5A, 1'b0, 1'b1, 1'b0, 48'h0000_0000_0000, 16'h0000);
    push_beat(8'hA5, 1'b1, 1'b1, 1'b0, 48'h8000_0000_0001, 16'h0001);
    // Self-addressed frame is dropped whole.
    push_beat(8'h11, 1'b1, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF, 16'h0806);
    push_beat(8'h22, 1'b0, 1'b0, 1'b0, 48'h0000_0000_0000, 16'h0000);
    push_beat(8'h33, 1'b0, 1'b1, 1'b0, 48'h0000_0000_0000, 16'h0000);
    // Beats outside any frame are ignored.
    push_beat(8'h44, 1'b0, 1'b1, 1'b0, 48'h1234_5678_9ABC, 16'h1234);
    push_beat(8'h55, 1'b0, 1'b0, 1'b0, 48'h1234_5678_9ABC, 16'h1234);
    // A new opening beat abandons the open frame without padding.
    push_beat(8'h01, 1'b1, 1'b0, 1'b0, 48'h1111_1111_1111, 16'h0800);
    push_beat(8'h02, 1'b1, 1'b0, 1'b0, 48'h2222_2222_2222, 16'h86DD);
    push_beat(8'h03, 1'b0, 1'b1, 1'b0, 48'h0000_0000_0000, 16'h0000);
    push_beat(8'h00, 1'b1, 1'b1, 1'b1, 48'h5555_5555_5555, 16'h0000);
    push_beat(8'h77, 1'b0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hAAAA);
    push_beat(8'h07, 1'b1, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF, 16'h0800);
    push_beat(8'h08, 1'b1, 1'b1, 1'b0, 48'hAAAA_AAAA_AAAA, 16'h5555);
    push_quiesce();

    // Station address at zero.
    push_station_mac(48'h0000_0000_0000);
    push_beat(8'h00, 1'b0, 1'b0, 1'b1, 48'h0000_0000_0000, 16'h0000);
    push_beat(8'hFF, 1'b1, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    push_beat(8'h00, 1'b0, 1'b1, 1'b0, 48'h0000_0000_0000, 16'h0000);
    push_beat(8'h10, 1'b1, 1'b0, 1'b0, 48'h0000_0000_0000, 16'h0800);
    push_beat(8'h20, 1'b0, 1'b0, 1'b1, 48'h0000_0000_0001, 16'h0800);
    push_beat(8'h30, 1'b0, 1'b1, 1'b0, 48'h0000_0000_0000, 16'h0000);

    // Random phases, each under its own station address.
    phase_macs = '{rand48(), 48'h0000_0000_0000, rand48(), 48'hFFFF_FFFF_FFFF};
    for (p = 0; p < 4; p++) begin
      mac = phase_macs[p];
      push_quiesce();
      push_station_mac(mac);
      // One long frame so the payload counter saturates.
      if (p == 0) push_frame(50, rand48(), 1'b1);
      start = stim_items;
      while (stim_items - start < 30) begin
        pick = $urandom_range(0, 99);
        dest = ($urandom_range(0, 7) == 0) ? mac : rand48();
        if (pick < 70) begin
          if ($urandom_range(0, 7) == 0) begin
            push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b1, dest,
                      16'($urandom_range(0, 65535)));
          end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 10);
            push_frame(len, dest, 1'b1);
          end
        end else if (pick < 82) begin
          push_frame($urandom_range(1, 6), dest, 1'b0);
        end else if (pick < 90) begin
          push_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0,
                    rand48(), 16'($urandom_range(0, 65535)));
        end else begin
          push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dest,
                    16'($urandom_range(0, 65535)));
        end
      end
    end

    // Reset, then let the drivers run until the plan is used up.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_tvalid || cfg_we || quiescing) @(posedge clk);
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatches == 0 && frame_bytes_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
